### hw/rtl/tpi_pkg.sv
// Shared types, codes and widths of the table polynomial interpolator.
package tpi_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int MAX_POINTS_DEF  = 8;

	localparam int DATA_W     = 32;
	localparam int ENTRY_W    = 8;
	localparam int TS_W       = 9;
	localparam int IP_W       = 4;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	// Internal arithmetic: values are held to +-(2^46 - 1) in 48-bit registers.
	localparam int FRAC   = 16;
	localparam int H_W    = 33;
	localparam int VAL_W  = 48;
	localparam int QMAG_W = 46;
	localparam int DEN_W  = 33;
	localparam int DIV_W  = QMAG_W + FRAC;
	localparam int HALF_W = 23;
	localparam int PP_W   = H_W + HALF_W;
	localparam int ACC_W  = H_W + QMAG_W;

	localparam logic signed [VAL_W-1:0] SAT_LIM = 48'sh3FFF_FFFF_FFFF;

	localparam logic [2:0] MUL_LAST = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_BAD_SIZE = 2'd1,
		STAT_DUP_X    = 2'd2
	} status_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TABLE_SIZE    = 1'b0,
		CFG_INTERP_POINTS = 1'b1
	} cfg_reg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_QUERY,
		OP_BAD,
		OP_RD_FIRST,
		OP_RD_LAST,
		OP_ASC,
		OP_BIS_RD,
		OP_BIS_UPD,
		OP_WIN,
		OP_LD_RD,
		OP_LD_WR,
		OP_NV_START,
		OP_NV_Q,
		OP_NV_MUL,
		OP_NV_WR,
		OP_NV_DY,
		OP_FINISH
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_RD_LAST,
		ST_ASC,
		ST_BIS,
		ST_BIS_CMP,
		ST_LD_RD,
		ST_LD_WR,
		ST_NV_START,
		ST_NV_DIV,
		ST_NV_MUL,
		ST_NV_WR,
		ST_NV_DY,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic size_bad;
		logic bis_more;
		logic dup;
		logic ld_last;
		logic div_busy;
		logic mul_last;
		logic row_last;
		logic nv_last;
		logic out_free;
	} flags_t;

endpackage

### hw/rtl/tpi_div.sv
// Restoring divider, one quotient bit per cycle.
module tpi_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tpi_pkg::DIV_W-1:0] dividend,
	input  logic [tpi_pkg::DEN_W-1:0] divisor,
	output logic                      busy,
	output logic [tpi_pkg::DIV_W-1:0] quot
);
	import tpi_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic             busy_q;
	logic [CW-1:0]    cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dvs_q;
	logic [DEN_W:0]   r2;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign r2   = {rem_q, quo_q[DIV_W-1]};
	assign ge   = r2 >= {1'b0, dvs_q};
	assign diff = r2 - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not go busy after start");

endmodule

### hw/rtl/tpi_dp.sv
// Datapath: table memories, search registers, Neville tableau and output register.
module tpi_dp #(
	parameter int TABLE_DEPTH = tpi_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_POINTS  = tpi_pkg::MAX_POINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tpi_pkg::op_t                   op,
	output tpi_pkg::flags_t                flags,
	input  logic                           cfg_write,
	input  logic [tpi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpi_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [tpi_pkg::ENTRY_W-1:0]    entry_index,
	input  logic signed [tpi_pkg::DATA_W-1:0] x_value,
	input  logic signed [tpi_pkg::DATA_W-1:0] y_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [tpi_pkg::DATA_W-1:0] y_result,
	output logic signed [tpi_pkg::DATA_W-1:0] error_estimate,
	output logic [tpi_pkg::ENTRY_W-1:0]    window_start,
	output logic [tpi_pkg::STATUS_W-1:0]   status
);
	import tpi_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SW = AW + 2;

	function automatic logic signed [VAL_W-1:0] sat_lim(input logic signed [VAL_W:0] v);
		logic signed [VAL_W:0] lim;
		lim = {SAT_LIM[VAL_W-1], SAT_LIM};
		if (v > lim) begin
			return SAT_LIM;
		end else if (v < -lim) begin
			return -SAT_LIM;
		end
		return v[VAL_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [VAL_W-1:0] v);
		if (v > 48'sh0000_7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -48'sh0000_8000_0000) begin
			return 32'sh8000_0000;
		end
		return v[DATA_W-1:0];
	endfunction

	// Product magnitude with 16 fraction bits dropped, saturated and signed.
	function automatic logic signed [VAL_W-1:0] mul_res(input logic [ACC_W-1:0] acc,
		input logic neg);
		logic [ACC_W-FRAC-1:0] sh;
		logic [VAL_W-1:0]      m;
		sh = acc[ACC_W-1:FRAC];
		if (|sh[ACC_W-FRAC-1:QMAG_W]) begin
			m = VAL_W'(SAT_LIM);
		end else begin
			m = VAL_W'(sh[QMAG_W-1:0]);
		end
		return neg ? -$signed(m) : $signed(m);
	endfunction

	// Table storage.
	logic [DATA_W-1:0] x_mem [TABLE_DEPTH];
	logic [DATA_W-1:0] y_mem [TABLE_DEPTH];
	logic [DATA_W-1:0] rd_x_q, rd_y_q;
	logic [AW-1:0]     rd_addr;
	logic              mem_we;

	// Configuration and query registers.
	logic [TS_W-1:0]          ts_q;
	logic [IP_W-1:0]          ip_q;
	logic signed [DATA_W-1:0] xq_q, x0_q;
	logic                     asc_q;
	logic [AW-1:0]            lo_q, hi_q, mid_q, start_q;
	logic [PW-1:0]            k_q, i_q, m_q, nsp_q;
	logic [H_W-1:0]           dif_q;
	logic signed [VAL_W-1:0]  y_q, dy_q;
	status_code_t             status_q;

	// Tableau.
	logic signed [H_W-1:0]   ha_q [MAX_POINTS];
	logic signed [H_W-1:0]   hb_q [MAX_POINTS];
	logic signed [VAL_W-1:0] c_q  [MAX_POINTS];
	logic signed [VAL_W-1:0] d_q  [MAX_POINTS];
	logic signed [H_W-1:0]   ho_q, hp_q;
	logic                    qneg_q;
	logic [QMAG_W-1:0]       qmag_q;
	logic [2:0]              mcnt_q;
	logic [PP_W-1:0]         pp_q;
	logic [ACC_W-1:0]        accc_q, accd_q;

	// Output register.
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_y_q, out_err_q;
	logic [ENTRY_W-1:0]       out_ws_q;
	status_code_t             out_stat_q;

	// Combinational terms.
	logic                    size_bad, bis_more, out_free, dup, ld_last;
	logic [AW:0]             mid_sum;
	logic [AW-1:0]           mid, ld_addr, start_c;
	logic signed [SW-1:0]    st_raw, st_lim, st_c;
	logic signed [H_W-1:0]   h_new;
	logic [H_W-1:0]          h_abs;
	logic [PW-1:0]           c_idx, d_idx, hb_idx;
	logic signed [VAL_W-1:0] c_rd, d_rd, w, dy_sel, y_sum;
	logic signed [H_W:0]     den;
	logic                    dneg;
	logic [DEN_W-1:0]        dmag;
	logic [QMAG_W-1:0]       wmag;
	logic [DIV_W-1:0]        quot;
	logic                    div_busy;
	logic [H_W-1:0]          ahp, aho, mul_a;
	logic [HALF_W-1:0]       mul_b;
	logic [PP_W-1:0]         mul_p;
	logic                    take_c;

	assign size_bad = (ts_q < 9'd2) || (int'(ts_q) > TABLE_DEPTH) || (ip_q < 4'd2)
		|| (int'(ip_q) > MAX_POINTS) || ({5'b0, ip_q} > ts_q);

	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[AW:1];
	assign bis_more = ({1'b0, hi_q} - {1'b0, lo_q}) > (AW + 1)'(1);

	// Window start: centered on the bracket, then clamped to the table.
	always_comb begin
		st_raw = $signed({2'b00, lo_q}) - $signed(SW'((ip_q - 4'd2) >> 1));
		st_lim = $signed(SW'(ts_q)) - $signed(SW'(ip_q));
		st_c   = (st_raw > st_lim) ? st_lim : st_raw;
		if (st_c < 0) begin
			st_c = '0;
		end
		start_c = st_c[AW-1:0];
	end

	assign ld_addr = start_q + AW'(k_q);
	assign h_new   = $signed({rd_x_q[DATA_W-1], rd_x_q}) - $signed({xq_q[DATA_W-1], xq_q});
	assign h_abs   = h_new[H_W-1] ? H_W'(-h_new) : H_W'(h_new);
	assign ld_last = k_q == PW'(ip_q - 4'd1);

	always_comb begin
		dup = 1'b0;
		for (int j = 0; j < MAX_POINTS; j++) begin
			if ((j < int'(k_q)) && (ha_q[j] == h_new)) begin
				dup = 1'b1;
			end
		end
	end

	always_comb begin
		case (op)
			OP_RD_FIRST: rd_addr = '0;
			OP_RD_LAST:  rd_addr = AW'(ts_q - 9'd1);
			OP_BIS_RD:   rd_addr = mid;
			OP_LD_RD:    rd_addr = ld_addr;
			default:     rd_addr = '0;
		endcase
	end

	assign mem_we = (op == OP_LOAD) && (int'(entry_index) < TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			x_mem[AW'(entry_index)] <= x_value;
			y_mem[AW'(entry_index)] <= y_value;
		end
		rd_x_q <= x_mem[rd_addr];
		rd_y_q <= y_mem[rd_addr];
	end

	// Tableau reads: one muxed address per array.
	assign c_idx  = (op == OP_NV_DY) ? nsp_q : i_q + PW'(1);
	assign d_idx  = (op == OP_NV_DY) ? nsp_q - PW'(1) : i_q;
	assign hb_idx = i_q + m_q;
	assign c_rd   = c_q[c_idx];
	assign d_rd   = d_q[d_idx];
	assign w      = sat_lim($signed({c_rd[VAL_W-1], c_rd}) - $signed({d_rd[VAL_W-1], d_rd}));
	assign wmag   = w[VAL_W-1] ? QMAG_W'(-w) : QMAG_W'(w);
	assign den    = $signed({ha_q[i_q][H_W-1], ha_q[i_q]})
		- $signed({hb_q[hb_idx][H_W-1], hb_q[hb_idx]});
	assign dneg   = den[H_W];
	assign dmag   = dneg ? DEN_W'(-den) : DEN_W'(den);

	tpi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (op == OP_NV_START),
		.dividend ({wmag, {FRAC{1'b0}}}),
		.divisor  (dmag),
		.busy     (div_busy),
		.quot     (quot)
	);

	// Products are built from two 23-bit halves of the quotient.
	assign ahp   = hp_q[H_W-1] ? H_W'(-hp_q) : H_W'(hp_q);
	assign aho   = ho_q[H_W-1] ? H_W'(-ho_q) : H_W'(ho_q);
	assign mul_a = (mcnt_q < 3'd2) ? ahp : aho;
	assign mul_b = mcnt_q[0] ? qmag_q[QMAG_W-1:HALF_W] : qmag_q[HALF_W-1:0];
	assign mul_p = {{HALF_W{1'b0}}, mul_a} * {{H_W{1'b0}}, mul_b};

	assign take_c = (2 * int'(nsp_q)) < (int'(ip_q) - int'(m_q));
	assign dy_sel = take_c ? c_rd : d_rd;
	assign y_sum  = sat_lim($signed({y_q[VAL_W-1], y_q}) + $signed({dy_sel[VAL_W-1], dy_sel}));

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q        <= TS_W'(256);
			ip_q        <= IP_W'(4);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_TABLE_SIZE:    ts_q <= cfg_data;
					CFG_INTERP_POINTS: ip_q <= cfg_data[IP_W-1:0];
					default:           ;
				endcase
			end
			if (op == OP_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_QUERY: begin
				xq_q     <= x_value;
				status_q <= STAT_OK;
				dy_q     <= '0;
			end
			OP_BAD: status_q <= STAT_BAD_SIZE;
			OP_RD_LAST: x0_q <= rd_x_q;
			OP_ASC: begin
				asc_q <= $signed(rd_x_q) >= x0_q;
				lo_q  <= '0;
				hi_q  <= AW'(ts_q - 9'd1);
			end
			OP_BIS_RD: mid_q <= mid;
			OP_BIS_UPD: begin
				if (($signed(xq_q) >= $signed(rd_x_q)) == asc_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q;
				end
			end
			OP_WIN: begin
				start_q <= start_c;
				k_q     <= '0;
				i_q     <= '0;
				m_q     <= PW'(1);
			end
			OP_LD_WR: begin
				ha_q[k_q] <= h_new;
				hb_q[k_q] <= h_new;
				c_q[k_q]  <= VAL_W'($signed(rd_y_q));
				d_q[k_q]  <= VAL_W'($signed(rd_y_q));
				k_q       <= k_q + PW'(1);
				// Track the entry nearest the query; its y seeds the result.
				if ((k_q == '0) || (h_abs < dif_q)) begin
					dif_q <= h_abs;
					nsp_q <= k_q;
					y_q   <= VAL_W'($signed(rd_y_q));
				end
				if (dup) begin
					status_q <= STAT_DUP_X;
				end
			end
			OP_NV_START: begin
				ho_q   <= ha_q[i_q];
				hp_q   <= hb_q[hb_idx];
				qneg_q <= w[VAL_W-1] ^ dneg;
			end
			OP_NV_Q: begin
				qmag_q <= (|quot[DIV_W-1:QMAG_W]) ? SAT_LIM[QMAG_W-1:0] : quot[QMAG_W-1:0];
				mcnt_q <= '0;
			end
			OP_NV_MUL: begin
				pp_q   <= mul_p;
				mcnt_q <= mcnt_q + 3'd1;
				case (mcnt_q)
					3'd1:    accd_q <= ACC_W'(pp_q);
					3'd2:    accd_q <= accd_q + (ACC_W'(pp_q) << HALF_W);
					3'd3:    accc_q <= ACC_W'(pp_q);
					3'd4:    accc_q <= accc_q + (ACC_W'(pp_q) << HALF_W);
					default: ;
				endcase
			end
			OP_NV_WR: begin
				d_q[i_q] <= mul_res(accd_q, hp_q[H_W-1] ^ qneg_q);
				c_q[i_q] <= mul_res(accc_q, ho_q[H_W-1] ^ qneg_q);
				i_q      <= i_q + PW'(1);
			end
			OP_NV_DY: begin
				dy_q <= dy_sel;
				y_q  <= y_sum;
				if (!take_c) begin
					nsp_q <= nsp_q - PW'(1);
				end
				m_q <= m_q + PW'(1);
				i_q <= '0;
			end
			OP_FINISH: begin
				out_y_q    <= (status_q == STAT_OK) ? sat32(y_q) : '0;
				out_err_q  <= (status_q == STAT_OK) ? sat32(dy_q) : '0;
				out_ws_q   <= (status_q == STAT_BAD_SIZE) ? '0 : ENTRY_W'(start_q);
				out_stat_q <= status_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		flags.size_bad = size_bad;
		flags.bis_more = bis_more;
		flags.dup      = dup;
		flags.ld_last  = ld_last;
		flags.div_busy = div_busy;
		flags.mul_last = mcnt_q == MUL_LAST;
		flags.row_last = i_q == (PW'(ip_q - 4'd1) - m_q);
		flags.nv_last  = m_q == PW'(ip_q - 4'd1);
		flags.out_free = out_free;
	end

	assign out_valid      = out_valid_q;
	assign y_result       = out_y_q;
	assign error_estimate = out_err_q;
	assign window_start   = out_ws_q;
	assign status         = out_stat_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_stat_q != STAT_OK)) |-> ((out_y_q == '0) && (out_err_q == '0)))
		else $error("failed request carries nonzero values");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_NV_START) |-> !div_busy)
		else $error("division started while divider busy");

	a_fin_room: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_FINISH) |-> out_free)
		else $error("result written over an untaken result");

endmodule

### hw/rtl/tpi_ctrl.sv
// Controller state machine that sequences search, window load and tableau.
module tpi_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            func,
	output logic            in_ready,
	input  tpi_pkg::flags_t flags,
	output tpi_pkg::op_t    op
);
	import tpi_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (func) begin
						op      = OP_QUERY;
						state_d = ST_RD_FIRST;
					end else begin
						op = OP_LOAD;
					end
				end
			end
			ST_RD_FIRST: begin
				if (flags.size_bad) begin
					op      = OP_BAD;
					state_d = ST_FIN;
				end else begin
					op      = OP_RD_FIRST;
					state_d = ST_RD_LAST;
				end
			end
			ST_RD_LAST: begin
				op      = OP_RD_LAST;
				state_d = ST_ASC;
			end
			ST_ASC: begin
				op      = OP_ASC;
				state_d = ST_BIS;
			end
			ST_BIS: begin
				if (flags.bis_more) begin
					op      = OP_BIS_RD;
					state_d = ST_BIS_CMP;
				end else begin
					op      = OP_WIN;
					state_d = ST_LD_RD;
				end
			end
			ST_BIS_CMP: begin
				op      = OP_BIS_UPD;
				state_d = ST_BIS;
			end
			ST_LD_RD: begin
				op      = OP_LD_RD;
				state_d = ST_LD_WR;
			end
			ST_LD_WR: begin
				op = OP_LD_WR;
				if (flags.dup) begin
					state_d = ST_FIN;
				end else if (flags.ld_last) begin
					state_d = ST_NV_START;
				end else begin
					state_d = ST_LD_RD;
				end
			end
			ST_NV_START: begin
				op      = OP_NV_START;
				state_d = ST_NV_DIV;
			end
			ST_NV_DIV: begin
				if (!flags.div_busy) begin
					op      = OP_NV_Q;
					state_d = ST_NV_MUL;
				end
			end
			ST_NV_MUL: begin
				op = OP_NV_MUL;
				if (flags.mul_last) begin
					state_d = ST_NV_WR;
				end
			end
			ST_NV_WR: begin
				op      = OP_NV_WR;
				state_d = flags.row_last ? ST_NV_DY : ST_NV_START;
			end
			ST_NV_DY: begin
				op      = OP_NV_DY;
				state_d = flags.nv_last ? ST_FIN : ST_NV_START;
			end
			ST_FIN: begin
				if (flags.out_free) begin
					op      = OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func) |=> (state_q == ST_RD_FIRST))
		else $error("query request did not start a search");

	a_load_stay: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !func) |=> (state_q == ST_IDLE))
		else $error("load request left the idle state");

endmodule

### hw/rtl/table_polynomial_interpolator.sv
// Top level of the table polynomial interpolator.
// The block holds a table of (x, y) sample points in signed Q16.16 and answers
// query requests with a polynomial interpolation through interp_points table
// entries around the query x. A load request (func 0) writes one entry and
// gives no result. A query request (func 1) judges the table order, brackets
// x by bisection through the single read port of the table memories, loads the
// window point by point, and then runs the Neville tableau, whose
// interp_points*(interp_points-1)/2 divisions each go through a shared
// restoring divider at one quotient bit per cycle, with setup before and a
// multiplication after each division. A query with a bad size setting skips
// the search and the tableau. One request is worked on at a time, and the next
// request is taken as soon as the block is idle again, even while a result
// still waits in the output register. Configuration writes take effect at
// once and must be made only while the block is idle. Table entries that are
// never loaded read back as unknown values. The table memories need no
// clearing after reset.
module table_polynomial_interpolator #(
	parameter int TABLE_DEPTH = tpi_pkg::TABLE_DEPTH_DEF,
	parameter int MAX_POINTS  = tpi_pkg::MAX_POINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [tpi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tpi_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [tpi_pkg::ENTRY_W-1:0]       entry_index,
	input  logic signed [tpi_pkg::DATA_W-1:0] x_value,
	input  logic signed [tpi_pkg::DATA_W-1:0] y_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tpi_pkg::DATA_W-1:0] y_result,
	output logic signed [tpi_pkg::DATA_W-1:0] error_estimate,
	output logic [tpi_pkg::ENTRY_W-1:0]       window_start,
	output logic [tpi_pkg::STATUS_W-1:0]      status
);
	import tpi_pkg::*;

	// Command from the controller and status flags back from the datapath.
	op_t    op;
	flags_t flags;

	tpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_ready (in_ready),
		.flags    (flags),
		.op       (op)
	);

	tpi_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_POINTS  (MAX_POINTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.flags          (flags),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.entry_index    (entry_index),
		.x_value        (x_value),
		.y_value        (y_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.y_result       (y_result),
		.error_estimate (error_estimate),
		.window_start   (window_start),
		.status         (status)
	);

endmodule

### dv/table_polynomial_interpolator_tb.sv
// Self-checking testbench for the table polynomial interpolator.
`timescale 1ns / 100ps

module table_polynomial_interpolator_tb;
	import tpi_pkg::*;

	localparam longint LIM46 = 64'sh3FFF_FFFF_FFFF;
	localparam int CYCLE_LIMIT = 30_000_000;

	typedef struct {
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] err;
		logic [ENTRY_W-1:0]       ws;
		logic [STATUS_W-1:0]      st;
	} interp_result_t;

	typedef enum bit {ROW_CFG, ROW_REQ} row_kind_t;

	// One directed row is either a register write or a request. A request row
	// marked bad_size carries its expectation directly: all zero, bad size.
	typedef struct {
		row_kind_t   kind;
		cfg_reg_t    sel;
		int          data;
		bit          fn;
		bit [7:0]    idx;
		bit [31:0]   x;
		bit [31:0]   y;
		bit          bad_size;
	} dir_row_t;

	logic clk, arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_ready, func;
	logic [ENTRY_W-1:0] entry_index;
	logic signed [DATA_W-1:0] x_value, y_value;
	logic out_valid, out_ready;
	logic signed [DATA_W-1:0] y_result, error_estimate;
	logic [ENTRY_W-1:0] window_start;
	logic [STATUS_W-1:0] status;

	// Shadow copy of the block's state and settings, kept by the sender.
	longint x_tab[256];
	longint y_tab[256];
	int tsize_sh, npts_sh;

	interp_result_t pending_results[$];
	int errors;
	int cycle_count;
	bit calm;      // when set, neither side idles
	bit hold;      // receiver held off by the back-pressure process
	bit press_go;

	table_polynomial_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .entry_index(entry_index), .x_value(x_value), .y_value(y_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.y_result(y_result), .error_estimate(error_estimate),
		.window_start(window_start), .status(status)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// Fixed-point helpers. Every intermediate is held to +-(2^46 - 1);
	// products and quotients work on magnitudes and truncate toward zero.
	// ---------------------------------------------------------------
	function automatic longint clamp46(longint v);
		if (v > LIM46) return LIM46;
		if (v < -LIM46) return -LIM46;
		return v;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return -64'sh8000_0000;
		return v;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		logic [127:0] p;
		longint unsigned ua, ub;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = {64'd0, ua} * {64'd0, ub};
		p = p >> 16;
		if (p > LIM46) p = LIM46;
		return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint fx_div(longint a, longint b);
		longint unsigned ua, ub, qm;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		if (ub == 0) return 0;
		qm = (ua << 16) / ub;
		if (qm > LIM46) qm = LIM46;
		return ((a < 0) != (b < 0)) ? -longint'(qm) : longint'(qm);
	endfunction

	// Bracket the query by bisection, place the window, then run Neville's
	// tableau over it. The last correction becomes the error estimate.
	function automatic interp_result_t interpolate(longint xq);
		interp_result_t r;
		longint xa[8], c[8], d[8];
		longint y, dy, dif, dift, ho, hp, w, q;
		int n, pts, lo, hi, mid, start, ns;
		bit asc;
		r = '{0, 0, 0, STAT_OK};
		n = tsize_sh;
		pts = npts_sh;
		if (n < 2 || n > 256 || pts < 2 || pts > 8 || pts > n) begin
			r.st = STAT_BAD_SIZE;
			return r;
		end
		// The table counts as ascending unless its last x is below the first.
		asc = x_tab[n-1] >= x_tab[0];
		lo = 0;
		hi = n - 1;
		while (hi - lo > 1) begin
			mid = (hi + lo) >> 1;
			if ((xq >= x_tab[mid]) == asc) lo = mid;
			else hi = mid;
		end
		start = lo - ((pts - 2) >> 1);
		if (start > n - pts) start = n - pts;
		if (start < 0) start = 0;
		r.ws = start[7:0];
		for (int i = 0; i < pts; i++) xa[i] = x_tab[start+i];
		for (int i = 0; i < pts; i++)
			for (int j = i + 1; j < pts; j++)
				if (xa[i] == xa[j]) begin
					r.st = STAT_DUP_X;
					return r;
				end
		ns = 0;
		dif = xa[0] - xq;
		if (dif < 0) dif = -dif;
		for (int i = 0; i < pts; i++) begin
			dift = xa[i] - xq;
			if (dift < 0) dift = -dift;
			if (dift < dif) begin
				ns = i;
				dif = dift;
			end
			c[i] = y_tab[start+i];
			d[i] = y_tab[start+i];
		end
		y = c[ns];
		ns--;
		dy = 0;
		for (int m = 1; m < pts; m++) begin
			for (int i = 0; i < pts - m; i++) begin
				ho = xa[i] - xq;
				hp = xa[i+m] - xq;
				w = clamp46(c[i+1] - d[i]);
				q = fx_div(w, ho - hp);
				d[i] = fx_mul(hp, q);
				c[i] = fx_mul(ho, q);
			end
			// Take the correction from the upper or lower path of the tableau.
			if (2 * (ns + 1) < pts - m) begin
				dy = c[(ns+1) & 7];
			end else begin
				dy = (ns >= 0) ? d[ns & 7] : 0;
				ns--;
			end
			y = clamp46(y + dy);
		end
		r.y = clamp32(y);
		r.err = clamp32(dy);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Sender side.
	// ---------------------------------------------------------------
	task automatic send(bit fn, bit [7:0] idx, bit [31:0] x, bit [31:0] y, bit bad_size);
		int gap;
		if (!calm && $urandom_range(0, 99) < 12) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		entry_index <= idx;
		x_value <= x;
		y_value <= y;
		do @(posedge clk); while (!in_ready);
		// The request was taken at this edge: update the shadow or predict.
		if (!fn) begin
			x_tab[idx] = longint'($signed(x));
			y_tab[idx] = longint'($signed(y));
		end else if (bad_size) begin
			pending_results.push_back('{0, 0, 0, STAT_BAD_SIZE});
		end else begin
			pending_results.push_back(interpolate(longint'($signed(x))));
		end
	endtask

	// Waits until every result is back. Loads give no result, so it then waits
	// further to let the last load land before a register is touched.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t sel, int data);
		cfg_write <= 1'b1;
		cfg_index <= sel;
		cfg_data <= data[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		if (sel == CFG_TABLE_SIZE) tsize_sh = data & 9'h1FF;
		else npts_sh = data & 4'hF;
		@(posedge clk);
	endtask

	// Loads the first n entries with strictly monotone x and random y.
	task automatic fill_monotone(int n, bit descending);
		longint stp, span, base, xi;
		bit [31:0] yv;
		if ($urandom_range(0, 1)) stp = $urandom_range(1, 1 << 17);
		else stp = $urandom_range(1, int'((64'd1 << 31) / n));
		span = stp * (n - 1);
		base = -64'sh8000_0000 + longint'($urandom_range(0, 32'hFFFF_FFFF - span));
		for (int i = 0; i < n; i++) begin
			xi = base + stp * (descending ? (n - 1 - i) : i);
			yv = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom_range(0, 1 << 22) - (1 << 21));
			send(1'b0, i[7:0], xi[31:0], yv, 1'b0);
		end
	endtask

	// A query mostly inside the span of the table ends, sometimes anywhere.
	function automatic bit [31:0] pick_query();
		longint a, b, lo_x, span;
		a = x_tab[0];
		b = x_tab[tsize_sh >= 2 && tsize_sh <= 256 ? tsize_sh - 1 : 255];
		lo_x = (a < b) ? a : b;
		span = (a < b) ? b - a : a - b;
		if ($urandom_range(0, 9) == 0 || span > 64'hFFFF_FFFE) return $urandom;
		return 32'(lo_x + longint'($urandom_range(0, 32'(span + 1))));
	endfunction

	// Directed rows, run with the Q16.16 ramp table x = i, y = i*i/256 already loaded.
	dir_row_t dir_rows[] = '{
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h8000_0000, 0, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h7FFF_FFFF, 0, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h0003_8000, 0, 0},
		'{ROW_CFG, CFG_TABLE_SIZE, 1, 0, 0, 0, 0, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h0001_0000, 0, 1},
		'{ROW_CFG, CFG_TABLE_SIZE, 257, 0, 0, 0, 0, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h0001_0000, 0, 1},
		'{ROW_CFG, CFG_TABLE_SIZE, 511, 0, 0, 0, 0, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h0001_0000, 0, 1},
		'{ROW_CFG, CFG_TABLE_SIZE, 3, 0, 0, 0, 0, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h0001_0000, 0, 1},
		'{ROW_CFG, CFG_TABLE_SIZE, 256, 0, 0, 0, 0, 0},
		'{ROW_CFG, CFG_INTERP_POINTS, 1, 0, 0, 0, 0, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h0001_0000, 0, 1},
		'{ROW_CFG, CFG_INTERP_POINTS, 15, 0, 0, 0, 0, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h0001_0000, 0, 1},
		'{ROW_CFG, CFG_INTERP_POINTS, 8, 0, 0, 0, 0, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h0007_4000, 0, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h00FF_0000, 0, 0},
		'{ROW_CFG, CFG_INTERP_POINTS, 4, 0, 0, 0, 0, 0},
		// Entry 5 takes the x of entry 6, so the window holds equal x values.
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 0, 5, 32'h0006_0000, 32'h7FFF_FFFF, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h0005_8000, 0, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 0, 5, 32'h0005_0000, 32'h8000_0000, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h0005_4000, 0, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 0, 255, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0},
		'{ROW_REQ, CFG_TABLE_SIZE, 0, 1, 0, 32'h7FFF_0000, 0, 0}
	};

	// Random phases: table size, points, and table order.
	int ph_size[7] = '{256, 256, 2, 9, 100, 256, 37};
	int ph_pts[7]  = '{4, 8, 2, 8, 3, 2, 5};

	initial begin
		int r;
		bit [31:0] v;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		func = 1'b0;
		entry_index = '0;
		x_value = '0;
		y_value = '0;
		errors = 0;
		calm = 1'b0;
		press_go = 1'b0;
		tsize_sh = 256;
		npts_sh = 4;
		for (int i = 0; i < 256; i++) begin
			x_tab[i] = 0;
			y_tab[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every entry is written before the first query reads the table.
		for (int i = 0; i < 256; i++)
			send(1'b0, i[7:0], i << 16, (i * i) << 8, 1'b0);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				settle();
				write_reg(dir_rows[k].sel, dir_rows[k].data);
			end else begin
				send(dir_rows[k].fn, dir_rows[k].idx, dir_rows[k].x, dir_rows[k].y,
					dir_rows[k].bad_size);
			end
		end

		for (int p = 0; p < 7; p++) begin
			settle();
			write_reg(CFG_TABLE_SIZE, ph_size[p]);
			write_reg(CFG_INTERP_POINTS, ph_pts[p]);
			calm = (p == 4);
			fill_monotone(ph_size[p], p[0]);
			for (int k = 0; k < 110; k++) begin
				if (p == 0 && k == 20) press_go = 1'b1;
				r = $urandom_range(0, 99);
				if (r < 70) begin
					send(1'b1, 8'($urandom), pick_query(), $urandom, 1'b0);
				end else begin
					// Noise: overwrite any entry, inside the table or not.
					v = $urandom;
					send(1'b0, v[7:0], $urandom, $urandom, 1'b0);
				end
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------
	// Receiver side: random ready, compare with the oldest expectation.
	// ---------------------------------------------------------------
	task automatic report(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		interp_result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report("unexpected result", y_result, 0);
				end else begin
					e = pending_results.pop_front();
					if (y_result !== e.y) report("y_result", y_result, e.y);
					if (error_estimate !== e.err)
						report("error_estimate", error_estimate, e.err);
					if (window_start !== e.ws) report("window_start", window_start, e.ws);
					if (status !== e.st) report("status", status, e.st);
				end
			end
			if (hold) out_ready <= 1'b0;
			else if (calm) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 99) >= 12);
		end
	end

	// Long hold-off on the result side while requests keep coming, so the
	// block fills up and has to stall its input.
	initial begin
		hold = 1'b0;
		wait (press_go);
		@(posedge clk);
		hold <= 1'b1;
		repeat (3000) @(posedge clk);
		hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule
